// File: src/dfr_pkg.sv
`default_nettype none
package dfr_pkg;

  localparam int MAX_RUN_DEF = 32;
  localparam int PIX_W       = 8;
  localparam int HDR_W       = 16;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SKIP = 2'd1,
    MODE_LIT  = 2'd2
  } mode_t;

endpackage
`default_nettype wire

// File: src/dfr_ram.sv
`default_nettype none
module dfr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/delta_frame_run_encoder.sv
`default_nettype none
// Delta-frame run encoder. Each input transaction carries one pixel pair
// (base byte, new byte) and tlast on the last pixel of a frame. Pixels whose
// bytes match form skip runs, sent as one header transaction with tuser high
// and tdata carrying minus the run length. Pixels whose bytes differ form
// literal runs, held in a MAX_RUN-entry byte RAM and sent as a header with
// plus the length followed by one data transaction (tuser low) per byte.
// A run closes when the pixel kind changes, when it reaches MAX_RUN pixels,
// or at frame end; out_tlast marks the final transaction of the frame.
// Each pixel is accepted in S_IDLE, then counted and, if literal, written to
// the RAM in S_APPEND. A closing run sends its header from S_HDR and its bytes
// from S_LIT at one per cycle unless the output stalls, each RAM read issued
// the cycle before its byte loads. in_tready is low while a pixel is processed.
module delta_frame_run_encoder
  import dfr_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] base_pixel, [15:8] new_pixel
  input  wire logic        in_tlast,   // frame_end
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] run_header, [23:16] data_byte
  output logic             out_tuser,  // is_header
  output logic             out_tlast   // last_of_frame
);

  localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam int LW = $clog2(MAX_RUN + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_HDR,
    S_LIT
  } state_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic [LW-1:0]     k_r, k_nxt;
  logic              phase2_r, phase2_nxt;
  logic [PIX_W-1:0]  pix_r, pix_nxt;
  mode_t             want_r, want_nxt;
  logic              end_r, end_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic              ohdr_r, ohdr_nxt;
  logic [HDR_W-1:0]  ohead_r, ohead_nxt;
  logic [PIX_W-1:0]  obyte_r, obyte_nxt;
  logic              olast_r, olast_nxt;

  logic              ld;
  logic [LW-1:0]     len_inc;
  logic [LW-1:0]     k_inc;
  logic [HDR_W-1:0]  len_ext;
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;
  logic              in_acc;
  mode_t             in_want;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_want    = (in_tdata[7:0] == in_tdata[15:8]) ? MODE_SKIP : MODE_LIT;
  // Output register takes a new transaction when empty or being drained.
  assign ld         = !ovalid_r || out_tready;
  assign len_inc    = len_r + LW'(1);
  assign k_inc      = k_r + LW'(1);
  assign len_ext    = {{(HDR_W-LW){1'b0}}, len_r};
  assign ram_we     = (state_r == S_APPEND) && (want_r == MODE_LIT);

  // Keep the read address on the byte the output register wants next, so
  // ram_rdata in S_LIT always belongs to k_r.
  always_comb begin
    ram_raddr = '0;
    if (state_r == S_LIT) begin
      ram_raddr = ld ? k_inc[AW-1:0] : k_r[AW-1:0];
    end
  end

  dfr_ram #(
    .WIDTH  (PIX_W),
    .DEPTH  (MAX_RUN),
    .ADDR_W (AW)
  ) u_lit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (pix_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    phase2_nxt = phase2_r;
    pix_nxt    = pix_r;
    want_nxt   = want_r;
    end_nxt    = end_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ohdr_nxt   = ohdr_r;
    ohead_nxt  = ohead_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pix_nxt  = in_tdata[15:8];
          want_nxt = in_want;
          end_nxt  = in_tlast;
          // Close the open run first when the pixel kind changes.
          if (mode_r != MODE_NONE && mode_r != in_want) begin
            phase2_nxt = 1'b0;
            state_nxt  = S_HDR;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end

      S_APPEND: begin
        mode_nxt = want_r;
        len_nxt  = len_inc;
        if (len_inc >= LW'(MAX_RUN) || end_r) begin
          phase2_nxt = 1'b1;
          state_nxt  = S_HDR;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_HDR: begin
        if (ld) begin
          ovalid_nxt = 1'b1;
          ohdr_nxt   = 1'b1;
          obyte_nxt  = '0;
          k_nxt      = '0;
          if (mode_r == MODE_SKIP) begin
            ohead_nxt = HDR_W'(0) - len_ext;
            olast_nxt = phase2_r && end_r;
            mode_nxt  = MODE_NONE;
            len_nxt   = '0;
            state_nxt = phase2_r ? S_IDLE : S_APPEND;
          end else begin
            ohead_nxt = len_ext;
            olast_nxt = 1'b0;
            state_nxt = S_LIT;
          end
        end
      end

      S_LIT: begin
        if (ld) begin
          ovalid_nxt = 1'b1;
          ohdr_nxt   = 1'b0;
          ohead_nxt  = '0;
          obyte_nxt  = ram_rdata;
          k_nxt      = k_inc;
          if (k_inc == len_r) begin
            olast_nxt = phase2_r && end_r;
            mode_nxt  = MODE_NONE;
            len_nxt   = '0;
            state_nxt = phase2_r ? S_IDLE : S_APPEND;
          end else begin
            olast_nxt = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= MODE_NONE;
      len_r    <= '0;
      k_r      <= '0;
      phase2_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      len_r    <= len_nxt;
      k_r      <= k_nxt;
      phase2_r <= phase2_nxt;
      ovalid_r <= ovalid_nxt;
    end
    pix_r   <= pix_nxt;
    want_r  <= want_nxt;
    end_r   <= end_nxt;
    ohdr_r  <= ohdr_nxt;
    ohead_r <= ohead_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {obyte_r, ohead_r};
  assign out_tuser  = ohdr_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import dfr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PIXEL_GOAL  = 480;
  localparam int DRAIN_WAIT  = 40;

  // One encoded transaction as the block should send it.
  typedef struct packed {
    logic              is_header;
    logic signed [15:0] run_header;
    logic [7:0]        data_byte;
    logic              last_of_frame;
  } enc_item_t;

  typedef struct {
    logic [7:0] base_px;
    logic [7:0] new_px;
  } pixel_pair_t;

  // Tracks the open run the same way the encoder does and keeps the encoded
  // transactions it owes, oldest first.
  class run_scoreboard;
    mode_t       mode;
    int unsigned count;
    logic [7:0]  lit_bytes[MAX_RUN_DEF];
    enc_item_t   owed_q[$];
    int          errors;
    int          checked;

    function new();
      mode    = MODE_NONE;
      count   = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function void push_item(logic hdr, logic [15:0] head, logic [7:0] data);
      enc_item_t item;
      item.is_header     = hdr;
      item.run_header    = head;
      item.data_byte     = data;
      item.last_of_frame = 1'b0;
      owed_q.push_back(item);
    endfunction

    // Close the open run: a skip run is one negative header, a literal run
    // is a positive header followed by its buffered bytes.
    function void flush_run();
      if (mode == MODE_SKIP && count > 0) begin
        push_item(1'b1, 16'd0 - 16'(count), 8'd0);
      end else if (mode == MODE_LIT && count > 0) begin
        push_item(1'b1, 16'(count), 8'd0);
        for (int k = 0; k < count && k < MAX_RUN_DEF; k++)
          push_item(1'b0, 16'd0, lit_bytes[k]);
      end
      mode  = MODE_NONE;
      count = 0;
    endfunction

    function void note_pixel(logic [7:0] base_px, logic [7:0] new_px, logic frame_end);
      mode_t     want;
      int        first;
      enc_item_t tail;
      want  = (base_px == new_px) ? MODE_SKIP : MODE_LIT;
      first = owed_q.size();
      if (mode != MODE_SKIP && mode != MODE_LIT) begin
        mode  = MODE_NONE;
        count = 0;
      end
      if (mode != MODE_NONE && mode != want)
        flush_run();
      mode = want;
      if (want == MODE_LIT && count < MAX_RUN_DEF)
        lit_bytes[count] = new_px;
      count++;
      if (count >= MAX_RUN_DEF || frame_end)
        flush_run();
      if (frame_end && owed_q.size() > first) begin
        tail = owed_q.pop_back();
        tail.last_of_frame = 1'b1;
        owed_q.push_back(tail);
      end
    endfunction

    function void check_result(logic hdr, logic [15:0] head, logic [7:0] data,
                               logic last);
      enc_item_t exp_item;
      if (owed_q.size() == 0) begin
        $error("unexpected output transaction: is_header=%0b run_header=%0d data_byte=%0d",
               hdr, $signed(head), data);
        errors++;
        return;
      end
      exp_item = owed_q.pop_front();
      checked++;
      if (exp_item.is_header !== hdr) begin
        $error("is_header mismatch: expected %0b, actual %0b", exp_item.is_header, hdr);
        errors++;
      end
      if (exp_item.run_header !== head) begin
        $error("run_header mismatch: expected %0d, actual %0d",
               exp_item.run_header, $signed(head));
        errors++;
      end
      if (exp_item.data_byte !== data) begin
        $error("data_byte mismatch: expected %0d, actual %0d", exp_item.data_byte, data);
        errors++;
      end
      if (exp_item.last_of_frame !== last) begin
        $error("last_of_frame mismatch: expected %0b, actual %0b",
               exp_item.last_of_frame, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] base_pixel, [15:8] new_pixel
  logic        in_tlast;   // frame_end
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [15:0] run_header, [23:16] data_byte
  logic        out_tuser;  // is_header
  logic        out_tlast;  // last_of_frame

  run_scoreboard sb;
  pixel_pair_t   frame_q[$];
  int            send_idle;
  int            recv_idle;
  int            pixels_sent;
  int            frames_sent;
  int            cycle_count;

  delta_frame_run_encoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d transactions still owed",
             cycle_count, sb.owed_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check every accepted transaction, then pick the next
  // ready value. Both reads see pre-edge values, so there is no race with
  // the block's own updates.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[15:0], out_tdata[23:16], out_tlast);
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Offer one pixel pair and hold it until the block takes it. A random
  // gap may follow; valid drops in the step of the acceptance, so the next
  // call never lowers and raises it in the same step.
  task automatic send_pixel(input logic [7:0] base_px, input logic [7:0] new_px,
                            input logic frame_end);
    in_tvalid <= 1'b1;
    in_tdata  <= {new_px, base_px};
    in_tlast  <= frame_end;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(base_px, new_px, frame_end);
    pixels_sent++;
    if (frame_end)
      frames_sent++;
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      in_tlast  <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  // Append a run of matching (skip) or differing (literal) pixel pairs.
  task automatic add_run(input bit literal, input int len);
    pixel_pair_t px;
    for (int i = 0; i < len; i++) begin
      px.base_px = 8'($urandom);
      px.new_px  = literal ? px.base_px ^ 8'($urandom_range(1, 255)) : px.base_px;
      frame_q.push_back(px);
    end
  endtask

  // Build one frame out of runs and send it, tlast on its final pixel.
  // Most runs are short; some reach past the run cap, and now and then the
  // frame is the worst case: a nearly full literal run closed by a skip
  // pixel that also ends the frame. Noise frames mix random pairs and
  // stray frame ends.
  task automatic send_frame();
    int runs;
    int pick;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      add_run(1'b1, MAX_RUN_DEF - 1);
      add_run(1'b0, 1);
    end else if (pick < 18) begin
      for (int i = 0; i < $urandom_range(1, 12); i++) begin
        frame_q.push_back('{base_px: 8'($urandom), new_px: 8'($urandom)});
      end
    end else begin
      runs = $urandom_range(1, 6);
      for (int r = 0; r < runs; r++) begin
        if ($urandom_range(0, 99) < 20)
          add_run(1'($urandom), $urandom_range(MAX_RUN_DEF - 6, MAX_RUN_DEF + 8));
        else
          add_run(1'($urandom), $urandom_range(1, 8));
      end
    end
    for (int i = 0; i < frame_q.size(); i++) begin
      if (pick >= 6 && pick < 18 && i < frame_q.size() - 1)
        send_pixel(frame_q[i].base_px, frame_q[i].new_px, ($urandom_range(0, 99) < 10));
      else
        send_pixel(frame_q[i].base_px, frame_q[i].new_px, (i == frame_q.size() - 1));
    end
  endtask

  initial begin
    sb          = new();
    cycle_count = 0;
    pixels_sent = 0;
    frames_sent = 0;
    send_idle   = 30;
    recv_idle   = 61;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 16'd0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-pixel frames of each kind at the byte extremes.
    send_pixel(8'h00, 8'h00, 1'b1);
    send_pixel(8'h00, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'h00, 1'b1);
    // Literal, skip pair, then a literal that ends the frame.
    send_pixel(8'hFF, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hAA, 8'h55, 1'b1);
    // Literal run closed by a skip pixel that also ends the frame.
    send_pixel(8'h01, 8'h02, 1'b0);
    send_pixel(8'h03, 8'h04, 1'b0);
    send_pixel(8'h05, 8'h06, 1'b0);
    send_pixel(8'h07, 8'h07, 1'b1);
    // Skip run closed by a literal pixel that ends the frame.
    send_pixel(8'h09, 8'h09, 1'b0);
    send_pixel(8'h09, 8'h09, 1'b0);
    send_pixel(8'h09, 8'h08, 1'b1);
    // Kind flips on every pixel.
    send_pixel(8'h01, 8'h01, 1'b0);
    send_pixel(8'h01, 8'h02, 1'b0);
    send_pixel(8'h02, 8'h02, 1'b0);
    send_pixel(8'h80, 8'h7F, 1'b1);

    // Random frames; switch the idle pattern at each third of the run.
    while (pixels_sent < PIXEL_GOAL) begin
      if (pixels_sent >= 2 * PIXEL_GOAL / 3) begin
        send_idle <= 0;
        recv_idle <= 0;
      end else if (pixels_sent >= PIXEL_GOAL / 3) begin
        send_idle <= 61;
        recv_idle <= 30;
      end
      send_frame();
    end
    // Close any open run left by a noise frame.
    send_pixel(8'h5A, 8'h5A, 1'b1);
    in_tvalid <= 1'b0;

    // Drain the owed transactions, then watch for stray ones.
    while (sb.owed_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d pixel pairs in %0d frames; checked %0d encoded transactions",
             pixels_sent, frames_sent, sb.checked);
    $display("Covered skip and literal runs up to and past the run cap, under three idle mixes");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
